// ===== rtl/core/rsc_pkg.sv =====
`timescale 1ns / 1ps

package rsc_pkg;

   localparam int unsigned DataWidth = 32;

   localparam logic [DataWidth-1:0] TicksPerSecondReset = 32'd32768;

   // request opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // register offsets
   localparam logic [2:0] REG_COUNT   = 3'd0;
   localparam logic [2:0] REG_MATCH   = 3'd1;
   localparam logic [2:0] REG_LOAD    = 3'd2;
   localparam logic [2:0] REG_CONTROL = 3'd3;
   localparam logic [2:0] REG_RAW     = 3'd4;
   localparam logic [2:0] REG_MASKED  = 3'd5;
   localparam logic [2:0] REG_CLEAR   = 3'd6;

   // control register bit positions
   localparam int unsigned CtrlEnableBit = 0;
   localparam int unsigned CtrlMaskBit   = 1;

   typedef struct packed {
      logic [1:0]           op;
      logic [2:0]           reg_index;
      logic [DataWidth-1:0] write_data;
   } req_word_type;

   typedef struct packed {
      logic [DataWidth-1:0] read_data;
      logic                 irq;
      logic                 access_error;
   } rsp_word_type;

endpackage

// ===== rtl/core/rsc_in_reg.sv =====
`timescale 1ns / 1ps

module rsc_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  drain,
   input  rsc_pkg::req_word_type word_in,
   output logic                  valid,
   output rsc_pkg::req_word_type word_out
);
   import rsc_pkg::*;

   logic         valid_ff, valid_in;
   req_word_type word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (drain) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign valid    = valid_ff;
   assign word_out = word_ff;

endmodule

// ===== rtl/core/rsc_engine.sv =====
`timescale 1ns / 1ps

module rsc_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                commit,
   input  rsc_pkg::req_word_type               word,
   input  logic                                csr_write_enable,
   input  logic [rsc_pkg::DataWidth-1:0]       csr_write_data,
   output rsc_pkg::rsp_word_type               result
);
   import rsc_pkg::*;

   logic [DataWidth-1:0] tps_ff, seconds_ff, prescale_ff, load_ff, match_ff;
   logic [DataWidth-1:0] seconds_in, prescale_in, load_in, match_in;
   logic                 enable_ff, mask_ff, raw_ff, armed_ff;
   logic                 enable_in, mask_in, raw_in, armed_in;

   logic [DataWidth-1:0] limit, prescale_next, seconds_inc;
   logic [DataWidth-1:0] read_data;
   logic                 access_error;

   // zero prescale behaves as one
   assign limit         = (tps_ff == '0) ? {{(DataWidth-1){1'b0}}, 1'b1} : tps_ff;
   assign prescale_next = prescale_ff + {{(DataWidth-1){1'b0}}, 1'b1};
   assign seconds_inc   = seconds_ff + {{(DataWidth-1){1'b0}}, 1'b1};

   always_comb begin
      seconds_in   = seconds_ff;
      prescale_in  = prescale_ff;
      load_in      = load_ff;
      match_in     = match_ff;
      enable_in    = enable_ff;
      mask_in      = mask_ff;
      raw_in       = raw_ff;
      armed_in     = armed_ff;
      read_data    = '0;
      access_error = 1'b0;

      unique case (word.op)
         OP_TICK: begin
            if (prescale_next >= limit) begin
               prescale_in = '0;
               seconds_in  = seconds_inc;
               if (armed_ff && (seconds_inc == match_ff)) begin
                  raw_in   = enable_ff;
                  armed_in = 1'b0;
               end
            end else begin
               prescale_in = prescale_next;
            end
         end
         OP_READ: begin
            unique case (word.reg_index)
               REG_COUNT:   read_data = seconds_ff;
               REG_MATCH:   read_data = match_ff;
               REG_LOAD:    read_data = load_ff;
               REG_CONTROL: read_data = {{(DataWidth-2){1'b0}}, mask_ff, enable_ff};
               REG_RAW:     read_data = {{(DataWidth-1){1'b0}}, raw_ff};
               REG_MASKED:  read_data = {{(DataWidth-1){1'b0}}, raw_ff & ~mask_ff};
               REG_CLEAR:   raw_in = 1'b0;
               default:     access_error = 1'b1;
            endcase
         end
         OP_WRITE: begin
            unique case (word.reg_index)
               REG_MATCH: begin
                  match_in = word.write_data;
                  // one-shot compare; fires at once when already equal
                  if (seconds_ff == word.write_data) begin
                     raw_in   = enable_ff;
                     armed_in = 1'b0;
                  end else begin
                     armed_in = 1'b1;
                  end
               end
               REG_LOAD: begin
                  seconds_in  = word.write_data;
                  load_in     = word.write_data;
                  prescale_in = '0;
                  if (word.write_data == match_ff) begin
                     raw_in   = enable_ff;
                     armed_in = 1'b0;
                  end else begin
                     armed_in = 1'b1;
                  end
               end
               REG_CONTROL: begin
                  mask_in   = word.write_data[CtrlMaskBit];
                  enable_in = word.write_data[CtrlEnableBit];
                  raw_in    = raw_ff & word.write_data[CtrlEnableBit];
               end
               default: access_error = 1'b1;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff      <= TicksPerSecondReset;
         seconds_ff  <= '0;
         prescale_ff <= '0;
         load_ff     <= '0;
         match_ff    <= '0;
         enable_ff   <= 1'b0;
         mask_ff     <= 1'b0;
         raw_ff      <= 1'b0;
         armed_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            tps_ff <= csr_write_data;
         end
         if (commit) begin
            seconds_ff  <= seconds_in;
            prescale_ff <= prescale_in;
            load_ff     <= load_in;
            match_ff    <= match_in;
            enable_ff   <= enable_in;
            mask_ff     <= mask_in;
            raw_ff      <= raw_in;
            armed_ff    <= armed_in;
         end
      end
   end

   // pending is always raw with the mask applied
   assign result.read_data    = read_data;
   assign result.irq          = raw_in & ~mask_in;
   assign result.access_error = access_error;

endmodule

// ===== rtl/core/rsc_out_reg.sv =====
`timescale 1ns / 1ps

module rsc_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  taken,
   input  rsc_pkg::rsp_word_type word_in,
   output logic                  valid,
   output rsc_pkg::rsp_word_type word_out
);
   import rsc_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (taken) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign valid    = valid_ff;
   assign word_out = word_ff;

endmodule

// ===== rtl/core/rtc_seconds_counter_with_match_irq_core.sv =====
`timescale 1ns / 1ps
// Real-time clock core: seconds counter, prescaler and match interrupt.
// Request channel (req_*): one word per clock tick, register read or
// register write. Response channel (rsp_*): exactly one word per request,
// carrying read data, the interrupt level after the request and an
// access error flag for unknown offsets or read-only targets.
// csr_write_enable/csr_write_data set ticks per second (zero acts as one);
// write it only while no request is in flight.
// A request is held in the input register until the response register is
// free. Throughput: one request per cycle while rsp_ready is high, through a
// two-stage path (input register, then state update into the response
// register). All state update is one combinational pass per request.
// When rsp_ready is low the response register holds; one more request is
// taken into the input register and then req_ready drops until the
// response is taken.
// Reset (synchronous, active high) empties both stages, zeroes all counters
// and interrupt bits and sets ticks per second to 32768.
module rtc_seconds_counter_with_match_irq_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  logic [2:0]                    req_reg_index,
   input  logic [rsc_pkg::DataWidth-1:0] req_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rsc_pkg::DataWidth-1:0] rsp_read_data,
   output logic                          rsp_irq,
   output logic                          rsp_access_error,
   input  logic                          csr_write_enable,
   input  logic [rsc_pkg::DataWidth-1:0] csr_write_data
);
   import rsc_pkg::*;

   req_word_type req_word, stage_word;
   rsp_word_type result, rsp_word;
   logic         stage_valid, advance, req_fire, rsp_fire;

   assign req_word.op         = req_op;
   assign req_word.reg_index  = req_reg_index;
   assign req_word.write_data = req_write_data;

   assign rsp_fire  = rsp_valid & rsp_ready;
   assign advance   = stage_valid & (~rsp_valid | rsp_ready);
   assign req_ready = ~stage_valid | advance;
   assign req_fire  = req_valid & req_ready;

   rsc_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (req_fire),
      .drain    (advance),
      .word_in  (req_word),
      .valid    (stage_valid),
      .word_out (stage_word)
   );

   rsc_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .commit           (advance),
      .word             (stage_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .result           (result)
   );

   rsc_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .taken    (rsp_fire),
      .word_in  (result),
      .valid    (rsp_valid),
      .word_out (rsp_word)
   );

   assign rsp_read_data    = rsp_word.read_data;
   assign rsp_irq          = rsp_word.irq;
   assign rsp_access_error = rsp_word.access_error;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !stage_valid))
      else $error("pipeline not empty after reset");

   a_error_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_access_error) |-> (rsp_read_data == '0))
      else $error("access error with nonzero read data");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid && !advance) |=> (stage_valid && $stable(stage_word)))
      else $error("stalled request word lost or changed");

   a_no_double_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !advance)
      else $error("response overwritten while stalled");

endmodule

// ===== tb/sv/rtc_seconds_counter_with_match_irq_core_tb.sv =====
`timescale 1ns / 1ps

module rtc_seconds_counter_with_match_irq_core_tb;
   import rsc_pkg::*;

   localparam logic [1:0] OP_NONE    = 2'd3;
   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int unsigned CycleLimit = 400000;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_op;
   logic [2:0]           req_reg_index;
   logic [DataWidth-1:0] req_write_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [DataWidth-1:0] rsp_read_data;
   logic                 rsp_irq;
   logic                 rsp_access_error;
   logic                 csr_write_enable;
   logic [DataWidth-1:0] csr_write_data;

   rtc_seconds_counter_with_match_irq_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_reg_index    (req_reg_index),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_irq          (rsp_irq),
      .rsp_access_error (rsp_access_error),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // clock model state
   logic [31:0] m_ticks_per_sec;
   logic [31:0] m_seconds;
   logic [31:0] m_prescale;
   logic [31:0] m_load;
   logic [31:0] m_match;
   logic        m_enable;
   logic        m_mask;
   logic        m_raw;
   logic        m_pending;
   logic        m_armed;

   rsp_word_type expected_rsp_q[$];
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  sender_idle_pct = 36;
   int unsigned  receiver_idle_pct = 78;
   int unsigned  rsp_stall_left = 0;

   function automatic void fire_match();
      m_raw = m_enable;
      m_pending = m_raw && !m_mask;
      m_armed = 1'b0;
   endfunction

   function automatic void arm_match();
      if (m_seconds == m_match) fire_match();
      else m_armed = 1'b1;
   endfunction

   function automatic rsp_word_type predict_rsp_word(logic [1:0] op, logic [2:0] idx,
                                                     logic [31:0] wdata);
      rsp_word_type w;
      logic [31:0]  tick_limit;
      logic [31:0]  next_prescale;
      w = '0;
      case (op)
         OP_TICK: begin
            tick_limit = (m_ticks_per_sec == 32'd0) ? 32'd1 : m_ticks_per_sec;
            next_prescale = m_prescale + 32'd1;
            if (next_prescale >= tick_limit) begin
               m_prescale = '0;
               m_seconds = m_seconds + 32'd1;
               if (m_armed && m_seconds == m_match) fire_match();
            end else begin
               m_prescale = next_prescale;
            end
         end
         OP_READ: begin
            case (idx)
               REG_COUNT: w.read_data = m_seconds;
               REG_MATCH: w.read_data = m_match;
               REG_LOAD: w.read_data = m_load;
               REG_CONTROL: begin
                  w.read_data[CtrlMaskBit] = m_mask;
                  w.read_data[CtrlEnableBit] = m_enable;
               end
               REG_RAW: w.read_data[0] = m_raw;
               REG_MASKED: w.read_data[0] = m_pending;
               REG_CLEAR: begin
                  m_raw = 1'b0;
                  m_pending = 1'b0;
               end
               default: w.access_error = 1'b1;
            endcase
         end
         OP_WRITE: begin
            case (idx)
               REG_MATCH: begin
                  m_match = wdata;
                  arm_match();
               end
               REG_LOAD: begin
                  m_seconds = wdata;
                  m_load = wdata;
                  m_prescale = '0;
                  arm_match();
               end
               REG_CONTROL: begin
                  m_mask = wdata[CtrlMaskBit];
                  m_enable = wdata[CtrlEnableBit];
                  m_raw = m_raw && m_enable;
                  m_pending = m_raw && !m_mask;
               end
               default: w.access_error = 1'b1;
            endcase
         end
         default: ;
      endcase
      w.irq = m_pending;
      return w;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got 0x%0h, expected 0x%0h (cycle %0d)", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(logic [1:0] op, logic [2:0] idx, logic [31:0] wdata);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_reg_index <= idx;
      req_write_data <= wdata;
      do @(posedge clock); while (!req_ready);
      expected_rsp_q.push_back(predict_rsp_word(op, idx, wdata));
      @(negedge clock);
   endtask

   task automatic wait_all_responses();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_rsp_q.size() != 0) @(negedge clock);
   endtask

   task automatic set_ticks_per_second(logic [31:0] value);
      wait_all_responses();
      repeat (2) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      m_ticks_per_sec = value;
   endtask

   task automatic send_random_word();
      int unsigned pick;
      logic [31:0] data;
      logic [2:0]  idx;
      pick = $urandom_range(99);
      data = $urandom();
      idx = 3'($urandom_range(7));
      if (pick < 40) send_word(OP_TICK, idx, data);
      else if (pick < 58) send_word(OP_READ, idx, data);
      else if (pick < 72)
         // mostly a match a few seconds ahead so the compare actually fires
         send_word(OP_WRITE, REG_MATCH,
                   ($urandom_range(7) == 0) ? data : m_seconds + $urandom_range(4));
      else if (pick < 77)
         send_word(OP_WRITE, REG_LOAD,
                   ($urandom_range(1) == 0) ? data : 32'hFFFF_FFFF - $urandom_range(3));
      else if (pick < 87) send_word(OP_WRITE, REG_CONTROL, data);
      else if (pick < 92) send_word(OP_READ, REG_CLEAR, data);
      else if (pick < 96) begin
         if (idx inside {REG_MATCH, REG_LOAD, REG_CONTROL}) idx = idx + 3'd3;
         send_word(OP_WRITE, idx, data);
      end else send_word(OP_NONE, idx, data);
   endtask

   task automatic test_register_map();
      for (int i = 0; i < 8; i++) send_word(OP_READ, 3'(i), 32'hFFFF_FFFF);
      send_word(OP_WRITE, REG_COUNT, 32'hFFFF_FFFF);
      send_word(OP_WRITE, REG_RAW, 32'h0);
      send_word(OP_WRITE, REG_MASKED, 32'hFFFF_FFFF);
      send_word(OP_WRITE, REG_CLEAR, 32'hFFFF_FFFF);
      send_word(OP_WRITE, REG_UNUSED, 32'h0);
      send_word(OP_NONE, REG_UNUSED, 32'hFFFF_FFFF);
   endtask

   task automatic test_match_interrupt();
      // zero prescale acts as one tick per second
      set_ticks_per_second(32'd0);
      send_word(OP_WRITE, REG_CONTROL, 32'h1);
      send_word(OP_WRITE, REG_MATCH, 32'd2);
      send_word(OP_TICK, REG_COUNT, 32'h0);
      send_word(OP_TICK, REG_COUNT, 32'h0);
      send_word(OP_READ, REG_RAW, 32'h0);
      send_word(OP_WRITE, REG_CONTROL, 32'h3);
      send_word(OP_READ, REG_MASKED, 32'h0);
      send_word(OP_READ, REG_CLEAR, 32'h0);
      send_word(OP_WRITE, REG_CONTROL, 32'h1);
      // equal at arming: fires at once, then the count wraps
      send_word(OP_WRITE, REG_LOAD, 32'hFFFF_FFFF);
      send_word(OP_WRITE, REG_MATCH, 32'hFFFF_FFFF);
      send_word(OP_TICK, REG_COUNT, 32'h0);
      send_word(OP_READ, REG_COUNT, 32'h0);
      send_word(OP_WRITE, REG_CONTROL, 32'h0);
      send_word(OP_READ, REG_RAW, 32'h0);
   endtask

   task automatic test_response_stall();
      wait_all_responses();
      rsp_stall_left = 300;
      sender_idle_pct = 0;
      for (int i = 0; i < 24; i++) send_random_word();
      // sender holds until everything has drained
      wait_all_responses();
   endtask

   task automatic test_random_traffic(int unsigned n_items, int unsigned s_pct,
                                      int unsigned r_pct, logic [31:0] tps);
      set_ticks_per_second(tps);
      sender_idle_pct = s_pct;
      receiver_idle_pct = r_pct;
      for (int i = 0; i < n_items; i++) send_random_word();
   endtask

   // receiver: random ready, or a forced hold-off while rsp_stall_left runs down
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = rsp_stall_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_read_data, 32'h0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", rsp_read_data, want.read_data);
            if (rsp_irq !== want.irq)
               report_mismatch("irq", 32'(rsp_irq), 32'(want.irq));
            if (rsp_access_error !== want.access_error)
               report_mismatch("access_error", 32'(rsp_access_error),
                               32'(want.access_error));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_TICK;
      req_reg_index = REG_COUNT;
      req_write_data = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      m_ticks_per_sec = TicksPerSecondReset;
      m_seconds = '0;
      m_prescale = '0;
      m_load = '0;
      m_match = '0;
      m_enable = 1'b0;
      m_mask = 1'b0;
      m_raw = 1'b0;
      m_pending = 1'b0;
      m_armed = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_register_map();
      test_match_interrupt();
      test_response_stall();
      test_random_traffic(260, 36, 78, 32'd1);
      test_random_traffic(260, 78, 36, 32'd3);
      test_random_traffic(260, 0, 0, 32'd2);
      test_random_traffic(40, 0, 0, 32'hFFFF_FFFF);
      test_random_traffic(40, 36, 36, TicksPerSecondReset);

      wait_all_responses();
      repeat (4) @(negedge clock);
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
